// ----- design/fpa_pkg.sv -----
package fpa_pkg;

   localparam int FRAC_BITS  = 8;
   localparam int DATA_W     = 32;
   localparam int DIV_W      = DATA_W + FRAC_BITS;
   localparam int PIPE_DEPTH = DIV_W + 2;

   typedef enum logic [3:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_GT,
      OP_LT,
      OP_GE,
      OP_LE,
      OP_EQ,
      OP_NE,
      OP_MIN,
      OP_MAX,
      OP_INC,
      OP_DEC,
      OP_FROM_INT,
      OP_TO_INT
   } op_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result_raw;
      logic                     compare_true;
      logic                     divide_by_zero;
      logic                     is_div;
   } side_type;

   typedef struct packed {
      logic [DIV_W-1:0]  dividend;
      logic [DATA_W-1:0] divisor;
      logic              neg;
      side_type          side;
   } div_req_type;

   typedef struct packed {
      logic [DATA_W-1:0] quotient;
      logic              neg;
      side_type          side;
   } div_rsp_type;

endpackage

// ----- design/fixed_point_alu_q24_8.sv -----
// Signed 32-bit fixed-point ALU, 8 fraction bits.
// Request channel: req_valid/req_stall carry req_op, req_operand_a and
// req_operand_b; a transfer happens on a clock edge with valid high and stall low.
// Response channel: rsp_valid/rsp_stall carry rsp_result_raw, rsp_compare_true
// and rsp_divide_by_zero, one response per request, in request order.
// Every op runs through the same pipeline: an input stage, an operand stage
// (multiplier product register, divider operand prep), then 40 divider stages
// that resolve one quotient bit each (data width plus fraction bits), then the
// response register. Throughput is one op per cycle for any mix of ops while
// req_stall is low.
// A response skid register sits behind the pipeline: when the receiver stalls
// a waiting response, the next finished result is parked there and req_stall
// rises for as long as it is occupied; the pipeline freezes and nothing is lost.
// req_stall is a register output and does not depend on any input combinationally.
// Synchronous reset empties the pipeline, the skid register and the response
// register; requests are taken in the first cycle after reset drops.
module fixed_point_alu_q24_8 import fpa_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [3:0]               req_op,
   input  logic signed [DATA_W-1:0] req_operand_a,
   input  logic signed [DATA_W-1:0] req_operand_b,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_result_raw,
   output logic                     rsp_compare_true,
   output logic                     rsp_divide_by_zero
);

   typedef struct packed {
      logic signed [DATA_W-1:0] result_raw;
      logic                     compare_true;
      logic                     divide_by_zero;
   } out_type;

   logic [PIPE_DEPTH-1:0]    vld_ff;
   logic                     skid_vld_ff;
   logic                     rsp_valid_ff;
   logic                     en;
   logic                     out_free;

   op_type                   op_ff;
   logic signed [DATA_W-1:0] a_ff;
   logic signed [DATA_W-1:0] b_ff;

   side_type                 side_ff;
   side_type                 side_in;
   logic                     is_mul_ff;
   logic                     is_mul_in;
   logic [DIV_W-1:0]         dividend_ff;
   logic [DIV_W-1:0]         dividend_in;
   logic [DATA_W-1:0]        divisor_ff;
   logic [DATA_W-1:0]        divisor_in;
   logic                     neg_ff;
   logic                     neg_in;
   logic [DATA_W-1:0]        mag_a;

   logic signed [DATA_W-1:0] mul_scaled;
   div_req_type              div_req;
   div_rsp_type              div_rsp;

   out_type                  fin;
   out_type                  skid_ff;
   out_type                  rsp_ff;

   assign en        = !skid_vld_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = skid_vld_ff;

   // input stage
   always_ff @(posedge clock) begin
      if (en) begin
         op_ff <= op_type'(req_op);
         a_ff  <= req_operand_a;
         b_ff  <= req_operand_b;
      end
   end

   // operand stage
   always_comb begin
      side_in        = '0;
      side_in.is_div = (op_ff == OP_DIV);
      is_mul_in      = (op_ff == OP_MUL);
      unique case (op_ff)
         OP_ADD:      side_in.result_raw = a_ff + b_ff;
         OP_SUB:      side_in.result_raw = a_ff - b_ff;
         OP_MUL:      side_in.result_raw = '0;
         OP_DIV:      side_in.divide_by_zero = (b_ff == '0);
         OP_GT:       side_in.compare_true = (a_ff > b_ff);
         OP_LT:       side_in.compare_true = (a_ff < b_ff);
         OP_GE:       side_in.compare_true = (a_ff >= b_ff);
         OP_LE:       side_in.compare_true = (a_ff <= b_ff);
         OP_EQ:       side_in.compare_true = (a_ff == b_ff);
         OP_NE:       side_in.compare_true = (a_ff != b_ff);
         OP_MIN:      side_in.result_raw = (a_ff < b_ff) ? a_ff : b_ff;
         OP_MAX:      side_in.result_raw = (a_ff > b_ff) ? a_ff : b_ff;
         OP_INC:      side_in.result_raw = a_ff + 32'sd1;
         OP_DEC:      side_in.result_raw = a_ff - 32'sd1;
         OP_FROM_INT: side_in.result_raw = a_ff <<< FRAC_BITS;
         OP_TO_INT:   side_in.result_raw = a_ff >>> FRAC_BITS;
      endcase
   end

   assign mag_a       = a_ff[DATA_W-1] ? DATA_W'(-a_ff) : DATA_W'(a_ff);
   assign divisor_in  = b_ff[DATA_W-1] ? DATA_W'(-b_ff) : DATA_W'(b_ff);
   assign dividend_in = {mag_a, {FRAC_BITS{1'b0}}};
   assign neg_in      = a_ff[DATA_W-1] ^ b_ff[DATA_W-1];

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff     <= side_in;
         is_mul_ff   <= is_mul_in;
         dividend_ff <= dividend_in;
         divisor_ff  <= divisor_in;
         neg_ff      <= neg_in;
      end
   end

   fpa_mul u_mul (
      .clock          (clock),
      .load           (en),
      .operand_a      (a_ff),
      .operand_b      (b_ff),
      .product_scaled (mul_scaled)
   );

   always_comb begin
      div_req.dividend = dividend_ff;
      div_req.divisor  = divisor_ff;
      div_req.neg      = neg_ff;
      div_req.side     = side_ff;
      if (is_mul_ff) begin
         div_req.side.result_raw = mul_scaled;
      end
   end

   fpa_div u_div (
      .clock (clock),
      .load  (en),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // result select
   always_comb begin
      fin.result_raw     = div_rsp.side.result_raw;
      fin.compare_true   = div_rsp.side.compare_true;
      fin.divide_by_zero = div_rsp.side.divide_by_zero;
      if (div_rsp.side.is_div && !div_rsp.side.divide_by_zero) begin
         fin.result_raw = div_rsp.neg ? DATA_W'(-div_rsp.quotient) : div_rsp.quotient;
      end
   end

   // valid tracking, response register and skid
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         skid_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en) begin
            vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_valid};
         end
         if (skid_vld_ff) begin
            if (out_free) begin
               rsp_valid_ff <= 1'b1;
               skid_vld_ff  <= 1'b0;
            end
         end else if (vld_ff[PIPE_DEPTH-1]) begin
            if (out_free) begin
               rsp_valid_ff <= 1'b1;
            end else begin
               skid_vld_ff <= 1'b1;
            end
         end else if (out_free) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (out_free) begin
            rsp_ff <= skid_ff;
         end
      end else if (vld_ff[PIPE_DEPTH-1]) begin
         if (out_free) begin
            rsp_ff <= fin;
         end else begin
            skid_ff <= fin;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_raw     = rsp_ff.result_raw;
   assign rsp_compare_true   = rsp_ff.compare_true;
   assign rsp_divide_by_zero = rsp_ff.divide_by_zero;

   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> rsp_valid_ff)
      else $error("skid occupied without a pending response");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff && !rsp_stall |=> !skid_vld_ff)
      else $error("skid did not drain on response transfer");

   a_dz_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.divide_by_zero |-> rsp_ff.result_raw == '0 && !rsp_ff.compare_true)
      else $error("divide by zero response carries data");

endmodule

// ----- design/fpa_mul.sv -----
module fpa_mul import fpa_pkg::*; (
   input  logic                     clock,
   input  logic                     load,
   input  logic signed [DATA_W-1:0] operand_a,
   input  logic signed [DATA_W-1:0] operand_b,
   output logic signed [DATA_W-1:0] product_scaled
);

   logic signed [2*DATA_W-1:0] product_ff;
   logic signed [2*DATA_W-1:0] product_in;

   assign product_in = operand_a * operand_b;

   always_ff @(posedge clock) begin
      if (load) begin
         product_ff <= product_in;
      end
   end

   // floor shift by the fraction width, wrapped to the data width
   assign product_scaled = product_ff[FRAC_BITS +: DATA_W];

endmodule

// ----- design/fpa_div.sv -----
module fpa_div import fpa_pkg::*; (
   input  logic        clock,
   input  logic        load,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [DATA_W-1:0] rem_ff     [DIV_W];
   logic [DATA_W-1:0] rem_in     [DIV_W];
   logic [DIV_W-1:0]  dvd_ff     [DIV_W];
   logic [DIV_W-1:0]  dvd_in     [DIV_W];
   logic [DATA_W-1:0] quo_ff     [DIV_W];
   logic [DATA_W-1:0] quo_in     [DIV_W];
   logic [DATA_W-1:0] divisor_ff [DIV_W];
   logic              neg_ff     [DIV_W];
   side_type          side_ff    [DIV_W];

   // restoring division, one quotient bit per stage, MSB first
   for (genvar k = 0; k < DIV_W; k++) begin : g_stage
      logic [DATA_W-1:0] rem_prev;
      logic [DIV_W-1:0]  dvd_prev;
      logic [DATA_W-1:0] quo_prev;
      logic [DATA_W-1:0] dsr_prev;
      logic              neg_prev;
      side_type          side_prev;
      logic [DATA_W:0]   trial;
      logic [DATA_W:0]   diff;
      logic              fits;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign dvd_prev  = req.dividend;
         assign quo_prev  = '0;
         assign dsr_prev  = req.divisor;
         assign neg_prev  = req.neg;
         assign side_prev = req.side;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign dvd_prev  = dvd_ff[k-1];
         assign quo_prev  = quo_ff[k-1];
         assign dsr_prev  = divisor_ff[k-1];
         assign neg_prev  = neg_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      assign trial     = {rem_prev, dvd_prev[DIV_W-1]};
      assign diff      = trial - {1'b0, dsr_prev};
      assign fits      = trial >= {1'b0, dsr_prev};
      assign rem_in[k] = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      assign dvd_in[k] = {dvd_prev[DIV_W-2:0], 1'b0};
      assign quo_in[k] = {quo_prev[DATA_W-2:0], fits};

      always_ff @(posedge clock) begin
         if (load) begin
            rem_ff[k]     <= rem_in[k];
            dvd_ff[k]     <= dvd_in[k];
            quo_ff[k]     <= quo_in[k];
            divisor_ff[k] <= dsr_prev;
            neg_ff[k]     <= neg_prev;
            side_ff[k]    <= side_prev;
         end
      end
   end

   assign rsp.quotient = quo_ff[DIV_W-1];
   assign rsp.neg      = neg_ff[DIV_W-1];
   assign rsp.side     = side_ff[DIV_W-1];

endmodule
